### hw/rtl/drc_pkg.sv
// Shared constants and types for the detector radiance calibration pipeline.
package drc_pkg;

	// Fixed table geometry
	localparam int NUM_GAIN_STATES  = 2;
	localparam int NUM_MIRROR_SIDES = 2;
	localparam int NUM_TAB          = 7;
	localparam int NUM_GAIN_TAB     = 4;

	// Field widths
	localparam int DN_W    = 14;
	localparam int ANGLE_W = 16;
	localparam int RAD_W   = 32;

	// Fixed point
	localparam int FRAC   = 16;
	localparam int T_W    = ANGLE_W + 8;   // angle moved to Q.16
	localparam int MAG_W  = 60;            // product magnitude limit 2^60-1
	localparam int PROD_W = MAG_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	// Pipeline depths
	localparam int MUL_LAT = 6;
	localparam int QUO_W   = RAD_W - 1;
	localparam int NB_W    = QUO_W - FRAC;
	localparam int DIV_LAT = QUO_W + 3;

	localparam logic signed [SUM_W-1:0] RVS_HI = SUM_W'(131072);  // 2.0
	localparam logic signed [SUM_W-1:0] RVS_LO = SUM_W'(32768);   // 0.5
	localparam logic [RAD_W-1:0] RAD_MAX = 32'h7FFF_FFFF;
	localparam logic [RAD_W-1:0] RAD_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		SEL_C0,
		SEL_C1,
		SEL_C2,
		SEL_DARK,
		SEL_A0,
		SEL_A1,
		SEL_A2
	} coef_sel_t;

	typedef enum logic [1:0] {
		REG_DARK_SUBTRACT_ENABLE,
		REG_LINE_MARGIN
	} cfg_reg_t;

	typedef enum logic {
		REQ_WRITE,
		REQ_CALIBRATE
	} req_t;

endpackage

### hw/rtl/detector_radiance_calibration.sv
// Top level of the detector radiance calibration pipeline.
// Converts raw detector counts to Q16.16 radiance, one sample per clock unless stalled.
// Load items (req_type 0) write one coefficient word into one of seven tables;
// calibrate items (req_type 1) look up gain, dark and RVS coefficients, evaluate
// (c0 + c1*x + c2*x^2) / (a0 + a1*t + a2*t^2) and give one result unless flagged.
// Load items, flagged samples and items with an out-of-range band give no result; a
// load with an out-of-range detector or table select writes nothing. Throughput is
// one item per cycle while the output does not stall. The latency is set by two
// chained six-stage multipliers and a 34-stage divider (31 radix-2 steps). A load
// takes effect for every calibrate item accepted after it. A stall on the output
// freezes the whole pipeline, so in_stall follows out_stall whenever a result is
// waiting. Tables are not cleared at reset; an entry must be loaded before it is used.
// Configuration registers are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while no item is in flight; the block does not enforce it.
module detector_radiance_calibration #(
	parameter int NUM_BANDS     = 7,
	parameter int NUM_DETECTORS = 16,
	parameter int COEF_WIDTH    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data,
	// item in
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [2:0]          band,
	input  logic                gain_state,
	input  logic [4:0]          scan_line,
	input  logic [3:0]          detector,
	input  logic                mirror_side,
	input  logic                flagged,
	input  logic [13:0]         dn_counts,
	input  logic signed [15:0]  incidence_angle,
	input  logic [2:0]          coef_select,
	input  logic signed [31:0]  coef_value,
	// result out
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  radiance,
	output logic                rvs_odd
);

	localparam int CW   = COEF_WIDTH;
	localparam int ML   = drc_pkg::MUL_LAT;
	localparam int PW   = drc_pkg::PROD_W;
	localparam int SW   = drc_pkg::SUM_W;
	localparam int TW   = drc_pkg::T_W;
	localparam int XW   = ((CW > 31) ? CW : 31) + 2;
	localparam int GAIN_DEPTH = NUM_BANDS * drc_pkg::NUM_GAIN_STATES * NUM_DETECTORS *
	                            drc_pkg::NUM_MIRROR_SIDES;
	localparam int RVS_DEPTH  = NUM_BANDS * NUM_DETECTORS * drc_pkg::NUM_MIRROR_SIDES;
	localparam int GW   = $clog2(GAIN_DEPTH);
	localparam int RW   = (RVS_DEPTH > 1) ? $clog2(RVS_DEPTH) : 1;
	localparam int DW   = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
	localparam int NST  = 4 + 2 * ML + drc_pkg::DIV_LAT;

	// configuration registers
	logic       dark_en_q;
	logic [3:0] margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_en_q <= 1'b0;
			margin_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				drc_pkg::REG_DARK_SUBTRACT_ENABLE: dark_en_q <= cfg_data[0];
				drc_pkg::REG_LINE_MARGIN:          margin_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves together; it only holds when a result is not taken
	logic [NST:2] vld_q;
	logic adv;

	assign adv      = !(vld_q[NST] && out_stall);
	assign in_stall = !adv;

	// ---- stage 0: validity checks, detector mapping and table addressing ----
	logic       band_ok, det_ok;
	logic [5:0] line_diff;
	logic [DW-1:0] det_line, det_sel;
	logic [31:0] gi_full, ri_full;

	assign band_ok   = {2'b0, band} < 5'(NUM_BANDS);
	assign det_ok    = {2'b0, detector} < 6'(NUM_DETECTORS);
	assign line_diff = {1'b0, scan_line} - {2'b0, margin_q};

	always_comb begin
		if (line_diff[5]) begin
			det_line = '0;
		end else if (line_diff > 6'(NUM_DETECTORS - 1)) begin
			det_line = DW'(NUM_DETECTORS - 1);
		end else begin
			det_line = DW'(line_diff);
		end
		det_sel = (req_type == drc_pkg::REQ_CALIBRATE) ? det_line : DW'(detector);
		gi_full = 32'(band) + 32'(NUM_BANDS) * (32'(gain_state) +
		          32'(drc_pkg::NUM_GAIN_STATES) * (32'(det_sel) +
		          32'(NUM_DETECTORS) * 32'(mirror_side)));
		ri_full = 32'(band) + 32'(NUM_BANDS) * (32'(det_sel) +
		          32'(NUM_DETECTORS) * 32'(mirror_side));
	end

	// ---- stage 1 ----
	logic wr_s1, cal_s1;
	logic [GW-1:0] gi_s1;
	logic [RW-1:0] ri_s1;
	logic [2:0] sel_s1;
	logic signed [CW-1:0] word_s1;
	logic [drc_pkg::DN_W-1:0] dn_s1, dn_s2;
	logic signed [TW-1:0] t_s1, t_s2, t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1  <= 1'b0;
			cal_s1 <= 1'b0;
			vld_q  <= '0;
		end else if (adv) begin
			wr_s1  <= in_valid && (req_type == drc_pkg::REQ_WRITE) && band_ok && det_ok &&
			          (coef_select <= drc_pkg::SEL_A2);
			cal_s1 <= in_valid && (req_type == drc_pkg::REQ_CALIBRATE) && band_ok && !flagged;
			vld_q  <= {vld_q[NST-1:2], cal_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gi_s1   <= gi_full[GW-1:0];
			ri_s1   <= ri_full[RW-1:0];
			sel_s1  <= coef_select;
			word_s1 <= CW'(coef_value);
			dn_s1   <= dn_counts;
			t_s1    <= {incidence_angle, 8'b0};
			dn_s2   <= dn_s1;
			t_s2    <= t_s1;
			t_s3    <= t_s2;
		end
	end

	// ---- coefficient tables: written and read between stage 1 and stage 2 ----
	logic [drc_pkg::NUM_TAB-1:0] tab_we;
	logic signed [CW-1:0] tab_rd_s2 [drc_pkg::NUM_TAB];

	always_comb begin
		tab_we = '0;
		if (wr_s1 && adv) begin
			unique case (sel_s1) inside
				drc_pkg::SEL_C0, drc_pkg::SEL_C1, drc_pkg::SEL_C2, drc_pkg::SEL_DARK,
				drc_pkg::SEL_A0, drc_pkg::SEL_A1, drc_pkg::SEL_A2: tab_we[sel_s1] = 1'b1;
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < drc_pkg::NUM_TAB; k++) begin : g_tab
		if (k < drc_pkg::NUM_GAIN_TAB) begin : g_gain
			logic signed [CW-1:0] mem [GAIN_DEPTH];
			always_ff @(posedge clk) begin
				if (tab_we[k]) begin
					mem[gi_s1] <= word_s1;
				end
				if (adv) begin
					tab_rd_s2[k] <= mem[gi_s1];
				end
			end
		end else begin : g_rvs
			logic signed [CW-1:0] mem [RVS_DEPTH];
			always_ff @(posedge clk) begin
				if (tab_we[k]) begin
					mem[ri_s1] <= word_s1;
				end
				if (adv) begin
					tab_rd_s2[k] <= mem[ri_s1];
				end
			end
		end
	end

	// ---- stage 3: counts in Q.16, dark removed when dark subtraction is enabled ----
	logic signed [XW-1:0] x_s3;
	logic signed [CW-1:0] c0_s3, c1_s3, c2_s3, a0_s3, a1_s3, a2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3  <= $signed({{(XW-30){1'b0}}, dn_s2, 16'b0}) -
			         (dark_en_q ? XW'(tab_rd_s2[drc_pkg::SEL_DARK]) : XW'(0));
			c0_s3 <= tab_rd_s2[drc_pkg::SEL_C0];
			c1_s3 <= tab_rd_s2[drc_pkg::SEL_C1];
			c2_s3 <= tab_rd_s2[drc_pkg::SEL_C2];
			a0_s3 <= tab_rd_s2[drc_pkg::SEL_A0];
			a1_s3 <= tab_rd_s2[drc_pkg::SEL_A1];
			a2_s3 <= tab_rd_s2[drc_pkg::SEL_A2];
		end
	end

	// ---- first multiply level: x*x, c1*x, t*t, a1*t ----
	logic signed [PW-1:0] pxx, pcx, ptt, pat, pcxx, patt;

	drc_qmul #(.AW(XW), .BW(XW)) u_mul_xx (
		.clk(clk), .en(adv), .a(x_s3), .b(x_s3), .p(pxx));
	drc_qmul #(.AW(CW), .BW(XW)) u_mul_cx (
		.clk(clk), .en(adv), .a(c1_s3), .b(x_s3), .p(pcx));
	drc_qmul #(.AW(TW), .BW(TW)) u_mul_tt (
		.clk(clk), .en(adv), .a(t_s3), .b(t_s3), .p(ptt));
	drc_qmul #(.AW(CW), .BW(TW)) u_mul_at (
		.clk(clk), .en(adv), .a(a1_s3), .b(t_s3), .p(pat));

	// coefficients held until the first level is done
	logic signed [CW-1:0] c0_dly_q [ML];
	logic signed [CW-1:0] c2_dly_q [ML];
	logic signed [CW-1:0] a0_dly_q [ML];
	logic signed [CW-1:0] a2_dly_q [ML];

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_dly_q[0] <= c0_s3;
			c2_dly_q[0] <= c2_s3;
			a0_dly_q[0] <= a0_s3;
			a2_dly_q[0] <= a2_s3;
			for (int i = 1; i < ML; i++) begin
				c0_dly_q[i] <= c0_dly_q[i-1];
				c2_dly_q[i] <= c2_dly_q[i-1];
				a0_dly_q[i] <= a0_dly_q[i-1];
				a2_dly_q[i] <= a2_dly_q[i-1];
			end
		end
	end

	// ---- second multiply level: c2*x^2, a2*t^2 ----
	drc_qmul #(.AW(CW), .BW(PW)) u_mul_cxx (
		.clk(clk), .en(adv), .a(c2_dly_q[ML-1]), .b(pxx), .p(pcxx));
	drc_qmul #(.AW(CW), .BW(PW)) u_mul_att (
		.clk(clk), .en(adv), .a(a2_dly_q[ML-1]), .b(ptt), .p(patt));

	// offset plus linear term, formed while the square term is in flight
	logic signed [SW-1:0] gpart_s10, rpart_s10;
	logic signed [SW-1:0] gpart_dly_q [ML-1];
	logic signed [SW-1:0] rpart_dly_q [ML-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			gpart_s10 <= SW'(c0_dly_q[ML-1]) + SW'(pcx);
			rpart_s10 <= SW'(a0_dly_q[ML-1]) + SW'(pat);
			gpart_dly_q[0] <= gpart_s10;
			rpart_dly_q[0] <= rpart_s10;
			for (int i = 1; i < ML - 1; i++) begin
				gpart_dly_q[i] <= gpart_dly_q[i-1];
				rpart_dly_q[i] <= rpart_dly_q[i-1];
			end
		end
	end

	// ---- gain and RVS polynomials complete ----
	logic signed [SW-1:0] gain_s16, rvs_s16;

	always_ff @(posedge clk) begin
		if (adv) begin
			gain_s16 <= gpart_dly_q[ML-2] + SW'(pcxx);
			rvs_s16  <= rpart_dly_q[ML-2] + SW'(patt);
		end
	end

	// ---- quotient, saturation and RVS flag; its last stage is the output register ----
	drc_div u_div (
		.clk      (clk),
		.en       (adv),
		.gain     (gain_s16),
		.rvs      (rvs_s16),
		.radiance (radiance),
		.rvs_odd  (rvs_odd)
	);

	assign out_valid = vld_q[NST];

endmodule

### hw/rtl/drc_qmul.sv
// Pipelined signed Q.16 multiply, truncated toward zero, magnitude saturated.
module drc_qmul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [AW-1:0]               a,
	input  logic signed [BW-1:0]               b,
	output logic signed [drc_pkg::PROD_W-1:0]  p
);

	localparam int HA  = (AW + 1) / 2;
	localparam int HB  = (BW + 1) / 2;
	localparam int PRW = AW + BW;
	localparam int EW  = (PRW > 77) ? PRW : 77;

	logic [AW-1:0] amag_s1;
	logic [BW-1:0] bmag_s1;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [HA+HB-1:0]           p00_s2;
	logic [HA+BW-HB-1:0]        p01_s2;
	logic [AW-HA+HB-1:0]        p10_s2;
	logic [AW-HA+BW-HB-1:0]     p11_s2;
	logic [PRW-1:0] lo_s3, hi_s3, sum_s4;
	logic [drc_pkg::MAG_W-1:0] mag_s5;
	logic signed [drc_pkg::PROD_W-1:0] p_s6;
	logic [EW-1:0] sh;
	logic sat;

	assign sh  = EW'(sum_s4) >> drc_pkg::FRAC;
	assign sat = |sh[EW-1:drc_pkg::MAG_W];

	always_ff @(posedge clk) begin
		if (en) begin
			amag_s1 <= a[AW-1] ? AW'(-a) : AW'(a);
			bmag_s1 <= b[BW-1] ? BW'(-b) : BW'(b);
			neg_s1  <= a[AW-1] ^ b[BW-1];
			// limb products
			p00_s2 <= amag_s1[HA-1:0] * bmag_s1[HB-1:0];
			p01_s2 <= amag_s1[HA-1:0] * bmag_s1[BW-1:HB];
			p10_s2 <= amag_s1[AW-1:HA] * bmag_s1[HB-1:0];
			p11_s2 <= amag_s1[AW-1:HA] * bmag_s1[BW-1:HB];
			neg_s2 <= neg_s1;
			lo_s3  <= PRW'(p00_s2) + (PRW'(p01_s2) << HB);
			hi_s3  <= (PRW'(p10_s2) << HA) + (PRW'(p11_s2) << (HA + HB));
			neg_s3 <= neg_s2;
			sum_s4 <= lo_s3 + hi_s3;
			neg_s4 <= neg_s3;
			mag_s5 <= sat ? {drc_pkg::MAG_W{1'b1}} : sh[drc_pkg::MAG_W-1:0];
			neg_s5 <= neg_s4;
			p_s6   <= neg_s5 ? -$signed({1'b0, mag_s5}) : $signed({1'b0, mag_s5});
		end
	end

	assign p = p_s6;

endmodule

### hw/rtl/drc_div.sv
// Pipelined Q.16 quotient of gain by RVS, one quotient bit per stage, with RVS range flag.
module drc_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [drc_pkg::SUM_W-1:0]  gain,
	input  logic signed [drc_pkg::SUM_W-1:0]  rvs,
	output logic signed [drc_pkg::RAD_W-1:0]  radiance,
	output logic                              rvs_odd
);

	localparam int SW = drc_pkg::SUM_W;
	localparam int QW = drc_pkg::QUO_W;
	localparam int NW = drc_pkg::NB_W;

	logic [SW-1:0] un_s1, ud_s1;
	logic neg_s1, odd_s1;

	logic [SW-1:0] rem_s2, ud_s2;
	logic [NW-1:0] nb_s2;
	logic ovf_s2, zero_s2, neg_s2, odd_s2;

	logic [SW-1:0] rem_pipe_q  [QW];
	logic [QW-1:0] quo_pipe_q  [QW];
	logic [SW-1:0] den_pipe_q  [QW];
	logic [NW-1:0] nb_pipe_q   [QW];
	logic          ovf_pipe_q  [QW];
	logic          zero_pipe_q [QW];
	logic          neg_pipe_q  [QW];
	logic          odd_pipe_q  [QW];

	logic signed [drc_pkg::RAD_W-1:0] radiance_q;
	logic odd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			un_s1  <= gain[SW-1] ? SW'(-gain) : SW'(gain);
			ud_s1  <= rvs[SW-1] ? SW'(-rvs) : SW'(rvs);
			neg_s1 <= gain[SW-1] ^ rvs[SW-1];
			odd_s1 <= (rvs > drc_pkg::RVS_HI) || (rvs < drc_pkg::RVS_LO);
			// quotient would need 32 or more bits: saturate
			rem_s2  <= un_s1 >> NW;
			ovf_s2  <= (un_s1 >> NW) >= ud_s1;
			zero_s2 <= (un_s1 == '0) && (ud_s1 == '0);
			nb_s2   <= un_s1[NW-1:0];
			ud_s2   <= ud_s1;
			neg_s2  <= neg_s1;
			odd_s2  <= odd_s1;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int BI = QW - 1 - k;
		logic [SW-1:0] rem_in, den_in;
		logic [QW-1:0] quo_in;
		logic [NW-1:0] nb_in;
		logic ovf_in, zero_in, neg_in, odd_in, nbit, ge;
		logic [SW:0] shifted;

		if (k == 0) begin : g_first
			assign rem_in  = rem_s2;
			assign quo_in  = '0;
			assign den_in  = ud_s2;
			assign nb_in   = nb_s2;
			assign ovf_in  = ovf_s2;
			assign zero_in = zero_s2;
			assign neg_in  = neg_s2;
			assign odd_in  = odd_s2;
		end else begin : g_next
			assign rem_in  = rem_pipe_q[k-1];
			assign quo_in  = quo_pipe_q[k-1];
			assign den_in  = den_pipe_q[k-1];
			assign nb_in   = nb_pipe_q[k-1];
			assign ovf_in  = ovf_pipe_q[k-1];
			assign zero_in = zero_pipe_q[k-1];
			assign neg_in  = neg_pipe_q[k-1];
			assign odd_in  = odd_pipe_q[k-1];
		end

		// low FRAC bits of the dividend are zero
		if (BI >= drc_pkg::FRAC) begin : g_bit
			assign nbit = nb_in[BI-drc_pkg::FRAC];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign shifted = {rem_in, nbit};
		assign ge      = shifted >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_pipe_q[k]  <= ge ? SW'(shifted - {1'b0, den_in}) : shifted[SW-1:0];
				quo_pipe_q[k]  <= {quo_in[QW-2:0], ge};
				den_pipe_q[k]  <= den_in;
				nb_pipe_q[k]   <= nb_in;
				ovf_pipe_q[k]  <= ovf_in;
				zero_pipe_q[k] <= zero_in;
				neg_pipe_q[k]  <= neg_in;
				odd_pipe_q[k]  <= odd_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			odd_q <= odd_pipe_q[QW-1];
			if (zero_pipe_q[QW-1]) begin
				radiance_q <= '0;
			end else if (ovf_pipe_q[QW-1]) begin
				radiance_q <= neg_pipe_q[QW-1] ? drc_pkg::RAD_MIN : drc_pkg::RAD_MAX;
			end else if (neg_pipe_q[QW-1]) begin
				radiance_q <= drc_pkg::RAD_W'(-$signed({1'b0, quo_pipe_q[QW-1]}));
			end else begin
				radiance_q <= $signed({1'b0, quo_pipe_q[QW-1]});
			end
		end
	end

	assign radiance = radiance_q;
	assign rvs_odd  = odd_q;

endmodule
